>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SDQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("sdq assertion failed");

// Same-cycle implication.
`define SDQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdq assertion failed");

// Next-cycle implication.
`define SDQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdq assertion failed");

`endif

>>> rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg
// Types and constants of the searchable deque.
// ----------------------------------------------------------------------------
package sdq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_DELETE     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_HEAD,
        S_TAIL,
        S_LATCH,
        S_DONE
    } state_t;

endpackage

>>> rtl/sdq_ram.sv
// ----------------------------------------------------------------------------
// sdq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sdq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/searchable_deque.sv
// ----------------------------------------------------------------------------
// searchable_deque
// Ring-buffer deque with search and order-keeping delete, one item at a time.
// ----------------------------------------------------------------------------
// Sequence: push writes the entry RAM directly; pop rereads head and tail
// (skipped when it empties the deque); search scans from the front until a
// match or the end; delete scans, shifts each later entry down one slot, then
// rereads head and tail. Reads share the single read port of the entry RAM.
// Throughput: one item in flight; the next is taken once the result is queued.
// Reset: clears count, front index, FSM and output valid; entry RAM is not
// cleared (unused slots are never read).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module searchable_deque (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic signed [31:0] m_popped_value,
    output logic [6:0]  m_found_position,
    output logic [6:0]  m_entry_count,
    output logic signed [31:0] m_head_value,
    output logic signed [31:0] m_tail_value
);

    localparam int AW = sdq_pkg::ADDR_W;
    localparam int CW = sdq_pkg::CNT_W;
    localparam int DW = sdq_pkg::DATA_W;

    sdq_pkg::state_t  state_reg, state_next;
    sdq_pkg::op_t     op_reg, op_next;
    sdq_pkg::status_t status_reg, status_next;

    logic [DW-1:0] val_reg, val_next;
    logic [DW-1:0] popped_reg, popped_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] front_reg, front_next;
    logic [DW-1:0] head_reg, head_next;
    logic [DW-1:0] tail_reg, tail_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [DW-1:0] m_popped_reg, m_popped_next;
    logic [6:0]    m_pos_reg, m_pos_next;
    logic [6:0]    m_count_reg, m_count_next;
    logic [DW-1:0] m_head_reg, m_head_next;
    logic [DW-1:0] m_tail_reg, m_tail_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic          is_empty, is_full;
    logic [CW-1:0] count_m1;

    sdq_ram #(
        .DEPTH (sdq_pkg::CAPACITY),
        .WIDTH (DW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(sdq_pkg::CAPACITY));
    assign count_m1 = count_reg - CW'(1);

    assign s_ready = (state_reg == sdq_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdq_pkg::S_IDLE;
            count_reg   <= '0;
            front_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            front_reg   <= front_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        val_reg      <= val_next;
        popped_reg   <= popped_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        m_status_reg <= m_status_next;
        m_popped_reg <= m_popped_next;
        m_pos_reg    <= m_pos_next;
        m_count_reg  <= m_count_next;
        m_head_reg   <= m_head_next;
        m_tail_reg   <= m_tail_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        val_next      = val_reg;
        popped_next   = popped_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_popped_next = m_popped_reg;
        m_pos_next    = m_pos_reg;
        m_count_next  = m_count_reg;
        m_head_next   = m_head_reg;
        m_tail_next   = m_tail_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        unique case (state_reg)
            sdq_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next     = sdq_pkg::op_t'(s_op);
                    val_next    = s_value;
                    status_next = sdq_pkg::ST_OK;
                    popped_next = '0;
                    pos_next    = '0;
                    state_next  = sdq_pkg::S_DONE;
                    case (sdq_pkg::op_t'(s_op))
                        sdq_pkg::OP_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = sdq_pkg::ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_reg + count_reg[AW-1:0];
                                ram_wdata  = s_value;
                                count_next = count_reg + CW'(1);
                                tail_next  = s_value;
                                if (is_empty) begin
                                    head_next = s_value;
                                end
                            end
                        end
                        sdq_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = sdq_pkg::ST_FULL;
                            end else begin
                                front_next = front_reg - AW'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = front_reg - AW'(1);
                                ram_wdata  = s_value;
                                count_next = count_reg + CW'(1);
                                head_next  = s_value;
                                if (is_empty) begin
                                    tail_next = s_value;
                                end
                            end
                        end
                        sdq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                status_next = sdq_pkg::ST_EMPTY;
                            end else begin
                                popped_next = tail_reg;
                                count_next  = count_m1;
                                state_next  = sdq_pkg::S_HEAD;
                            end
                        end
                        sdq_pkg::OP_POP_FRONT: begin
                            if (is_empty) begin
                                status_next = sdq_pkg::ST_EMPTY;
                            end else begin
                                popped_next = head_reg;
                                front_next  = front_reg + AW'(1);
                                count_next  = count_m1;
                                state_next  = sdq_pkg::S_HEAD;
                            end
                        end
                        sdq_pkg::OP_SEARCH, sdq_pkg::OP_DELETE: begin
                            if (is_empty) begin
                                status_next = sdq_pkg::ST_EMPTY;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                idx_next   = '0;
                                state_next = sdq_pkg::S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // ram_rdata holds the entry at offset idx_reg
            sdq_pkg::S_SCAN: begin
                if (ram_rdata == val_reg) begin
                    pos_next = idx_reg + CW'(1);
                    if (op_reg != sdq_pkg::OP_DELETE) begin
                        state_next = sdq_pkg::S_DONE;
                    end else if (idx_reg == count_m1) begin
                        count_next = count_m1;
                        state_next = sdq_pkg::S_HEAD;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = front_reg + idx_reg[AW-1:0] + AW'(1);
                        state_next = sdq_pkg::S_SHIFT;
                    end
                end else if ((idx_reg + CW'(1)) < count_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = front_reg + idx_reg[AW-1:0] + AW'(1);
                    idx_next   = idx_reg + CW'(1);
                end else begin
                    status_next = sdq_pkg::ST_NOTFOUND;
                    state_next  = sdq_pkg::S_DONE;
                end
            end

            // move entry idx+1 down to idx; read and write slots never coincide
            sdq_pkg::S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = front_reg + idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                if ((idx_reg + CW'(2)) < count_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = front_reg + idx_reg[AW-1:0] + AW'(2);
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    count_next = count_m1;
                    state_next = sdq_pkg::S_HEAD;
                end
            end

            sdq_pkg::S_HEAD: begin
                if (is_empty) begin
                    state_next = sdq_pkg::S_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = front_reg;
                    state_next = sdq_pkg::S_TAIL;
                end
            end

            sdq_pkg::S_TAIL: begin
                head_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = front_reg + count_m1[AW-1:0];
                state_next = sdq_pkg::S_LATCH;
            end

            sdq_pkg::S_LATCH: begin
                tail_next  = ram_rdata;
                state_next = sdq_pkg::S_DONE;
            end

            sdq_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_popped_next = popped_reg;
                    m_pos_next    = 7'(pos_reg);
                    m_count_next  = 7'(count_reg);
                    m_head_next   = is_empty ? '0 : head_reg;
                    m_tail_next   = is_empty ? '0 : tail_reg;
                    state_next    = sdq_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = sdq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_popped_value   = m_popped_reg;
    assign m_found_position = m_pos_reg;
    assign m_entry_count    = m_count_reg;
    assign m_head_value     = m_head_reg;
    assign m_tail_value     = m_tail_reg;

    `SDQ_ASSERT(a_count_bound, count_reg <= CW'(sdq_pkg::CAPACITY))
    `SDQ_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr)
    `SDQ_ASSERT_NXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != sdq_pkg::S_IDLE)
    `SDQ_ASSERT_IMP(a_scan_in_range, state_reg == sdq_pkg::S_SCAN, idx_reg < count_reg)
    `SDQ_ASSERT_IMP(a_done_no_ram, state_reg == sdq_pkg::S_DONE, !ram_we && !ram_re)

endmodule
